[hdl/assert_macros.svh]
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define TLE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tle_pkg.sv]
package tle_pkg;

   // character codes, 7-bit
   localparam logic [6:0] CHAR_BS      = 7'h08;
   localparam logic [6:0] CHAR_DEL     = 7'h7f;
   localparam logic [6:0] CHAR_LITERAL = 7'h16;
   localparam logic [6:0] CHAR_TAB     = 7'h09;
   localparam logic [6:0] CHAR_LF      = 7'h0a;
   localparam logic [6:0] CHAR_CR      = 7'h0d;
   localparam logic [6:0] CHAR_BELL    = 7'h07;
   localparam logic [6:0] CHAR_SPACE   = 7'h20;

   // result kinds
   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   // line store geometry
   localparam int STORE_DEPTH = 128;
   localparam int CHAR_W      = 7;

   // results per item are capped at eight, so the step counter stops at seven
   localparam logic [2:0] STEP_CAP_LAST = 3'd7;

   // work handed from front to back
   typedef enum logic [1:0] {
      OP_ECHO,
      OP_ERASE,
      OP_NEWLINE,
      OP_READ
   } tle_op_code_type;

   typedef struct packed {
      tle_op_code_type code;
      logic [6:0]      char_val;
      logic [6:0]      length;
   } tle_op_type;

   typedef struct packed {
      logic       valid;
      tle_op_type op;
   } tle_slot_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_READ
   } tle_front_state_type;

endpackage

[hdl/tle_ram.sv]
module tle_ram #(
   parameter int Width = 7,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/tle_queue.sv]
module tle_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  tle_pkg::tle_slot_type push,
   output logic                  full,
   output tle_pkg::tle_slot_type head,
   input  logic                  pop
);
   import tle_pkg::*;

   localparam int Depth = 2;
   localparam int PtrW  = $clog2(Depth);

   tle_op_type      entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff, count_in;
   logic            do_pop;

   assign full   = (count_ff == (PtrW+1)'(Depth));
   assign do_pop = pop && (count_ff != '0);

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({push.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.op;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.op    = entry_ff[rd_ptr_ff];

endmodule

[hdl/tle_front.sv]
module tle_front #(
   parameter int MAX_LINE = 125
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,
   input  logic                  req_tuser,
   input  logic                  q_full,
   output tle_pkg::tle_slot_type push
);
   import tle_pkg::*;

   tle_front_state_type state_ff, state_in;
   logic [6:0]          fill_ff, fill_in;
   logic [6:0]          done_ff, done_in;
   logic                literal_ff, literal_in;
   logic                in_range_ff, in_range_in;

   logic [6:0]          key;
   logic [6:0]          key_stored;
   logic [6:0]          read_index;
   logic                accept;
   logic                room;
   logic                wr_en;
   logic [6:0]          wr_data;
   logic                rd_en;
   logic [6:0]          rd_data;

   assign key        = req_tdata[6:0];
   assign read_index = req_tdata[14:8];
   assign req_tready = (state_ff == FRONT_IDLE) && !q_full;
   assign accept     = req_tvalid && req_tready;
   assign room       = (fill_ff < 7'(MAX_LINE));
   // a tab typed plainly is stored as a space
   assign key_stored = (key == CHAR_TAB) ? CHAR_SPACE : key;

   // classify the item, update line state, hand an op to the back
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      done_in     = done_ff;
      literal_in  = literal_ff;
      in_range_in = in_range_ff;
      push        = '0;
      wr_en       = 1'b0;
      wr_data     = key;
      rd_en       = 1'b0;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (accept && req_tuser) begin
               rd_en       = 1'b1;
               in_range_in = (read_index < done_ff);
               state_in    = FRONT_READ;
            end else if (accept) begin
               push.op.length = '0;
               priority if (literal_ff) begin
                  literal_in   = 1'b0;
                  push.valid   = 1'b1;
                  push.op.code = OP_ECHO;
                  if (room) begin
                     wr_en            = 1'b1;
                     fill_in          = fill_ff + 1'b1;
                     push.op.char_val = key;
                  end else begin
                     push.op.char_val = CHAR_BELL;
                  end
               end else if ((key == CHAR_BS || key == CHAR_DEL) && fill_ff != '0) begin
                  fill_in          = fill_ff - 1'b1;
                  push.valid       = 1'b1;
                  push.op.code     = OP_ERASE;
                  push.op.char_val = CHAR_BS;
               end else if (key == CHAR_LF || key == CHAR_CR) begin
                  done_in          = fill_ff;
                  fill_in          = '0;
                  push.valid       = 1'b1;
                  push.op.code     = OP_NEWLINE;
                  push.op.char_val = CHAR_LF;
                  push.op.length   = fill_ff;
               end else if (key == CHAR_LITERAL) begin
                  literal_in = 1'b1;
               end else if (key_stored < CHAR_SPACE || key_stored == CHAR_DEL || !room) begin
                  push.valid       = 1'b1;
                  push.op.code     = OP_ECHO;
                  push.op.char_val = CHAR_BELL;
               end else begin
                  wr_en            = 1'b1;
                  wr_data          = key_stored;
                  fill_in          = fill_ff + 1'b1;
                  push.valid       = 1'b1;
                  push.op.code     = OP_ECHO;
                  push.op.char_val = key_stored;
               end
            end
         end
         FRONT_READ: begin
            // read data is back from the store, zero beyond the line end
            push.valid       = 1'b1;
            push.op.code     = OP_READ;
            push.op.char_val = in_range_ff ? rd_data : '0;
            push.op.length   = '0;
            state_in         = FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FRONT_IDLE;
         fill_ff    <= '0;
         done_ff    <= '0;
         literal_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         done_ff    <= done_in;
         literal_ff <= literal_in;
      end
   end

   always_ff @(posedge clock) begin
      in_range_ff <= in_range_in;
   end

   // line store
   tle_ram #(
      .Width(CHAR_W),
      .Depth(STORE_DEPTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_ff),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(read_index),
      .rd_data(rd_data)
   );

endmodule

[hdl/tle_back.sv]
module tle_back #(
   parameter int TAB_STOP = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tle_pkg::tle_slot_type head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);
   import tle_pkg::*;

   localparam int ColW = $clog2(TAB_STOP);

   logic [ColW-1:0] col_ff, col_in;
   logic [ColW-1:0] col_next;
   logic [2:0]      step_ff, step_in;
   logic            valid_ff, valid_in;
   logic [6:0]      byte_ff, byte_in;
   logic [6:0]      len_ff, len_in;
   logic [1:0]      kind_ff, kind_in;
   logic            last_ff, last_in;
   logic            out_free;
   logic            emit;

   assign out_free = !valid_ff || rsp_tready;
   assign emit     = head.valid && out_free;
   assign col_next = (col_ff == ColW'(TAB_STOP - 1)) ? '0 : col_ff + 1'b1;

   // one result a cycle from the op at the head of the queue, while the result register is free
   always_comb begin
      col_in   = col_ff;
      step_in  = step_ff;
      byte_in  = byte_ff;
      len_in   = len_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;
      pop      = 1'b0;
      if (emit) begin
         valid_in = 1'b1;
         kind_in  = KIND_ECHO;
         len_in   = '0;
         last_in  = 1'b0;
         byte_in  = head.op.char_val;
         unique case (head.op.code)
            OP_ECHO: begin
               if (head.op.char_val == CHAR_TAB) begin
                  // spaces up to the next stop, eight at most
                  byte_in = CHAR_SPACE;
                  last_in = (col_next == '0) || (step_ff == STEP_CAP_LAST);
                  col_in  = last_in ? '0 : col_next;
               end else if (head.op.char_val == CHAR_LF) begin
                  byte_in = (step_ff == 3'd0) ? CHAR_CR : CHAR_LF;
                  last_in = (step_ff != 3'd0);
                  col_in  = '0;
               end else begin
                  last_in = 1'b1;
                  col_in  = col_next;
               end
            end
            OP_ERASE: begin
               // backspace, space, backspace
               byte_in = (step_ff == 3'd1) ? CHAR_SPACE : CHAR_BS;
               last_in = (step_ff == 3'd2);
               col_in  = col_next;
            end
            OP_NEWLINE: begin
               // cr, lf, then the line complete report
               priority case (step_ff)
                  3'd0: begin
                     byte_in = CHAR_CR;
                  end
                  3'd1: begin
                     byte_in = CHAR_LF;
                     col_in  = '0;
                  end
                  default: begin
                     kind_in = KIND_LINE;
                     byte_in = '0;
                     len_in  = head.op.length;
                     last_in = 1'b1;
                  end
               endcase
            end
            OP_READ: begin
               kind_in = KIND_READ;
               last_in = 1'b1;
            end
         endcase
         pop     = last_in;
         step_in = last_in ? 3'd0 : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      len_ff  <= len_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, len_ff, 1'b0, byte_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

[hdl/tty_line_editor_with_echo.sv]
// Terminal line editor with echo.
// Input channel req_*: one item per keystroke (req_tuser = 0) or per read of
// one byte of the last completed line (req_tuser = 1, position in read_index).
// Result channel rsp_*: echo bytes (kind 0), line complete with its length
// (kind 1) and read data (kind 2); rsp_tlast marks the final result of an item.
// A control-V keystroke produces no result, unless a control-V came before it.
// The front takes a keystroke in its idle state and a read through a read
// state (the line store has a registered read port), taking no new item there;
// it hands at most one op per item to a two-entry queue. The back sends one
// result per cycle from the op at the queue head while the result register
// is free: 1 result for a plain key or a read, 2 for an echoed newline, 3 for
// erase or line end, up to 8 for a tab. Read data passes the line store read
// register; every op passes the queue and then the result register.
// When the receiver stalls, the result register holds, the back stops, the
// queue fills and req_tready drops; no result is lost.
// Reset clears the fill count, line length, literal flag, echo column, queue
// and result valid; the line store is not cleared and needs no clearing pass.
module tty_line_editor_with_echo #(
   parameter int MAX_LINE = 125,
   parameter int TAB_STOP = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // key_byte [7:0], read_index [14:8], zero [15]
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte [7:0], line_length [14:8], zero [15]
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast
);
   import tle_pkg::*;

   tle_slot_type push;
   tle_slot_type head;
   logic         q_full;
   logic         pop;

   // accept and classify
   tle_front #(
      .MAX_LINE(MAX_LINE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_full    (q_full),
      .push      (push)
   );

   // op queue
   tle_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .full (q_full),
      .head (head),
      .pop  (pop)
   );

   // echo expansion and result output
   tle_back #(
      .TAB_STOP(TAB_STOP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

[hdl/tle_checker.sv]
`include "assert_macros.svh"

module tle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import tle_pkg::*;

   property p_rsp_hold;
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast);
   endproperty

   property p_line_last;
      rsp_tvalid && rsp_tuser == KIND_LINE |-> rsp_tlast && rsp_tdata[7:0] == 8'd0;
   endproperty

   property p_read_form;
      rsp_tvalid && rsp_tuser == KIND_READ |-> rsp_tlast && rsp_tdata[15:7] == 9'd0;
   endproperty

   property p_echo_form;
      rsp_tvalid && rsp_tuser != KIND_LINE |-> rsp_tdata[15:8] == 8'd0 && rsp_tuser != 2'd3;
   endproperty

   property p_reset_idle;
      reset |=> !rsp_tvalid;
   endproperty

   // a stalled result holds
   `TLE_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "stalled result changed")

   // line complete ends the results of its item and carries no byte
   `TLE_ASSERT(a_line_last, clock, reset, p_line_last, "line complete result malformed")

   // read data is a single 7-bit result with no length
   `TLE_ASSERT(a_read_form, clock, reset, p_read_form, "read result malformed")

   // echo bytes carry no length and the kind code is never unused
   `TLE_ASSERT(a_echo_form, clock, reset, p_echo_form, "echo result malformed")

   // no result is pending right after reset
   `TLE_ASSERT_ALWAYS(a_reset_idle, clock, p_reset_idle, "result valid after reset")

endmodule

bind tty_line_editor_with_echo tle_checker u_tle_checker (.*);

[verif/tb_tty_line_editor_with_echo.sv]
module tb_tty_line_editor_with_echo;
   timeunit 1ns;
   timeprecision 1ps;

   import tle_pkg::*;

   localparam int MAX_LINE   = 125;
   localparam int TAB_STOP   = 8;
   localparam int MAX_PER_ITEM = 8;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int RANDOM_ITEMS = 20;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [6:0] line_len;
      logic       last;
   } edit_result_type;

   typedef struct {
      bit         cmd;
      logic [7:0] key;
      logic [6:0] index;
      bit         typed;
      logic [1:0] kind;
      logic [7:0] data;
      logic [6:0] len;
   } edit_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // key_byte [7:0], read_index [14:8], zero [15]
   logic        req_tuser;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // out_byte [7:0], line_length [14:8], zero [15]
   logic [1:0]  rsp_tuser;   // kind
   logic        rsp_tlast;

   tty_line_editor_with_echo #(
      .MAX_LINE (MAX_LINE),
      .TAB_STOP (TAB_STOP)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // shadow copy of the editor state
   logic [6:0] line_chars [STORE_DEPTH];
   int         typed_count;
   int         finished_length;
   bit         literal_armed;
   int         echo_column;
   int         written_top;   // entries 0 .. written_top-1 have been stored

   edit_result_type item_res [$];
   edit_result_type edit_result_q [$];

   int mismatch_count;
   int idle_cycles;
   int sent_items;
   int burst_left;
   bit hold_off_req;

   edit_row_type directed_rows [25];

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // echo path: tab expansion, newline as cr lf, column tracking
   function automatic void emit_result(logic [1:0] k, logic [6:0] c, logic [6:0] n);
      if (item_res.size() < MAX_PER_ITEM)
         item_res.push_back('{k, {1'b0, c}, n, 1'b0});
   endfunction

   function automatic void echo_char(logic [6:0] c);
      if (c == CHAR_TAB) begin
         do begin
            emit_result(KIND_ECHO, CHAR_SPACE, 7'd0);
            echo_column = (echo_column + 1) % TAB_STOP;
         end while (echo_column != 0);
      end else if (c == CHAR_LF) begin
         emit_result(KIND_ECHO, CHAR_CR, 7'd0);
         emit_result(KIND_ECHO, CHAR_LF, 7'd0);
         echo_column = 0;
      end else begin
         emit_result(KIND_ECHO, c, 7'd0);
         echo_column = (echo_column + 1) % TAB_STOP;
      end
   endfunction

   function automatic void store_char(logic [6:0] c);
      if (typed_count < MAX_LINE) begin
         line_chars[typed_count] = c;
         typed_count++;
         if (typed_count > written_top)
            written_top = typed_count;
         echo_char(c);
      end else begin
         echo_char(CHAR_BELL);
      end
   endfunction

   // expected results of one accepted item, left in item_res
   function automatic void predict_edit(bit cmd, logic [6:0] c, logic [6:0] index);
      logic [6:0] k;
      item_res.delete();
      k = c;
      if (cmd) begin
         emit_result(KIND_READ, (index < finished_length) ? line_chars[index] : 7'd0, 7'd0);
      end else if (literal_armed) begin
         literal_armed = 1'b0;
         store_char(k);
      end else if ((k == CHAR_BS || k == CHAR_DEL) && typed_count > 0) begin
         typed_count--;
         echo_char(CHAR_BS);
         echo_char(CHAR_SPACE);
         echo_char(CHAR_BS);
      end else begin
         if (k == CHAR_TAB)
            k = CHAR_SPACE;
         if (k == CHAR_LF || k == CHAR_CR) begin
            echo_char(CHAR_LF);
            finished_length = typed_count;
            typed_count = 0;
            emit_result(KIND_LINE, 7'd0, finished_length[6:0]);
         end else if (k == CHAR_LITERAL) begin
            literal_armed = 1'b1;
         end else if (k < CHAR_SPACE || k == CHAR_DEL || typed_count >= MAX_LINE) begin
            echo_char(CHAR_BELL);
         end else begin
            store_char(k);
         end
      end
      if (item_res.size() > 0)
         item_res[item_res.size() - 1].last = 1'b1;
   endfunction

   // offer one item in bursts with random gaps, then record what it must produce
   task automatic send_item(input bit cmd, input logic [7:0] key, input logic [6:0] index,
                            input bit typed, input edit_result_type typed_res);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {1'b0, index, key};
      req_tuser  = cmd;
      do @(posedge clock); while (!req_tready);
      sent_items++;
      predict_edit(cmd, key[6:0], index);
      if (typed)
         edit_result_q.push_back(typed_res);
      else
         foreach (item_res[i]) edit_result_q.push_back(item_res[i]);
   endtask

   task automatic send_key(input logic [6:0] c);
      send_item(1'b0, {1'($urandom_range(0, 1)), c}, 7'($urandom_range(0, 127)), 1'b0, '0);
   endtask

   // reads stay on entries that have been stored at least once
   task automatic send_read();
      int index;
      if (written_top > 0) begin
         index = $urandom_range(0, 127);
         if (index >= written_top)
            index = $urandom_range(0, written_top - 1);
         send_item(1'b1, 8'($urandom_range(0, 255)), 7'(index), 1'b0, '0);
      end
   endtask

   // a line of random content closed by cr or lf
   task automatic type_line(input int len, input bit plain);
      int r;
      logic [6:0] c;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (plain || r < 70) begin
            c = 7'($urandom_range(32, 126));
         end else if (r < 78) begin
            c = CHAR_TAB;
         end else if (r < 86) begin
            c = $urandom_range(0, 1) ? CHAR_BS : CHAR_DEL;
         end else if (r < 92) begin
            send_key(CHAR_LITERAL);
            c = 7'($urandom_range(0, 127));
         end else begin
            c = 7'($urandom_range(0, 31));
         end
         send_key(c);
      end
      send_key($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (edit_result_q.size() != 0) @(posedge clock);
   endtask

   // receiver: ready pattern in modes of random length, plus one long hold-off
   initial begin
      int mode;
      int mode_left;
      rsp_tready = 1'b0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = (mode == 3) ? $urandom_range(1, 5) : $urandom_range(5, 40);
            end
            mode_left--;
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(0, 1));
               2: rsp_tready = ($urandom_range(0, 3) == 0);
               default: rsp_tready = 1'b0;
            endcase
         end
      end
   end

   // result checker and progress counter
   always @(posedge clock) begin : result_check
      edit_result_type got;
      edit_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind     = rsp_tuser;
            got.out_byte = rsp_tdata[7:0];
            got.line_len = rsp_tdata[14:8];
            got.last     = rsp_tlast;
            if (edit_result_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected item kind %0d byte %h len %0d last %b",
                           $time, got.kind, got.out_byte, got.line_len, got.last);
            end else begin
               want = edit_result_q.pop_front();
               if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                   got.line_len !== want.line_len || got.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: expected %0d/%h/%0d/%b, got %0d/%h/%0d/%b", $time,
                              want.kind, want.out_byte, want.line_len, want.last,
                              got.kind, got.out_byte, got.line_len, got.last);
               end
            end
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog on cycles without any accepted item
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("tty_line_editor_with_echo verification failed");
      $finish;
   end

   // stimulus
   initial begin
      int r;
      int mixed_start;
      edit_result_type typed_res;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      hold_off_req = 1'b0;
      mismatch_count = 0;
      idle_cycles = 0;
      sent_items = 0;
      burst_left = 0;
      typed_count = 0;
      finished_length = 0;
      literal_armed = 1'b0;
      echo_column = 0;
      written_top = 0;

      // cmd, key, index, typed, kind, data, len
      directed_rows = '{
         '{1'b0, 8'h41, 7'h7f, 1'b1, KIND_ECHO, 8'h41, 7'd0},
         '{1'b0, 8'hc2, 7'h00, 1'b1, KIND_ECHO, 8'h42, 7'd0},
         '{1'b0, {1'b0, CHAR_TAB}, 7'h2a, 1'b1, KIND_ECHO, {1'b0, CHAR_SPACE}, 7'd0},
         '{1'b0, {1'b0, CHAR_DEL}, 7'h55, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b0, {1'b1, CHAR_BS}, 7'h00, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b0, 8'h01, 7'h00, 1'b1, KIND_ECHO, {1'b0, CHAR_BELL}, 7'd0},
         '{1'b0, {1'b0, CHAR_LITERAL}, 7'h00, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b0, {1'b0, CHAR_TAB}, 7'h00, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b0, {1'b0, CHAR_LITERAL}, 7'h00, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b0, {1'b0, CHAR_LF}, 7'h00, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b0, {1'b0, CHAR_LITERAL}, 7'h00, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b0, {1'b1, CHAR_LITERAL}, 7'h00, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b0, {1'b0, CHAR_LITERAL}, 7'h00, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b0, {1'b0, CHAR_BS}, 7'h00, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b0, {1'b1, CHAR_CR}, 7'h00, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b1, 8'hff, 7'd0, 1'b1, KIND_READ, 8'h41, 7'd0},
         '{1'b1, 8'h00, 7'd1, 1'b1, KIND_READ, {1'b0, CHAR_TAB}, 7'd0},
         '{1'b1, 8'h5a, 7'd4, 1'b1, KIND_READ, {1'b0, CHAR_BS}, 7'd0},
         '{1'b0, {1'b0, CHAR_LF}, 7'h00, 1'b0, KIND_ECHO, 8'h00, 7'd0},
         '{1'b1, 8'h00, 7'd3, 1'b1, KIND_READ, 8'h00, 7'd0},
         '{1'b0, {1'b0, CHAR_DEL}, 7'h00, 1'b1, KIND_ECHO, {1'b0, CHAR_BELL}, 7'd0},
         '{1'b0, {1'b0, CHAR_BS}, 7'h00, 1'b1, KIND_ECHO, {1'b0, CHAR_BELL}, 7'd0},
         '{1'b0, 8'ha0, 7'h00, 1'b1, KIND_ECHO, 8'h20, 7'd0},
         '{1'b0, 8'h7e, 7'h00, 1'b1, KIND_ECHO, 8'h7e, 7'd0},
         '{1'b0, 8'h80, 7'h00, 1'b1, KIND_ECHO, {1'b0, CHAR_BELL}, 7'd0}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows
      foreach (directed_rows[i]) begin
         typed_res = '{directed_rows[i].kind, directed_rows[i].data,
                       directed_rows[i].len, 1'b1};
         send_item(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].index,
                   directed_rows[i].typed, typed_res);
      end

      // one line typed past its capacity under a long receiver hold-off
      hold_off_req = 1'b1;
      type_line(128, 1'b1);

      // sender pauses until every result is out, then reads back stored entries
      drain_results();
      repeat (4) send_read();

      // mixed lines, noise and reads
      mixed_start = sent_items;
      while (sent_items - mixed_start < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            type_line($urandom_range(0, 10), 1'b0);
            repeat ($urandom_range(1, 4)) send_read();
         end else if (r < 85) begin
            send_item(1'b0, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                      1'b0, '0);
         end else begin
            send_read();
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && edit_result_q.size() == 0)
         $display("tty_line_editor_with_echo verification clean");
      else
         $display("tty_line_editor_with_echo verification failed");
      $finish;
   end

endmodule
